// ----- rtl/core/gpiorb_pkg.sv -----
package gpiorb_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_SELECT = 3'd1,
        K_SET    = 3'd2,
        K_CLEAR  = 3'd3,
        K_LEVEL  = 3'd4,
        K_STORE  = 3'd5
    } t_kind;

    localparam logic [2:0] FN_INPUT  = 3'd0;
    localparam logic [2:0] FN_OUTPUT = 3'd1;

    localparam int MAX_PINS   = 64;
    localparam int FSEL_WORDS = 6;
    localparam int FSEL_PINS  = 60;
    localparam int STORE_WORDS = 17;

    localparam logic [7:0] OFF_SEL_LAST = 8'h14;
    localparam logic [7:0] OFF_SET0     = 8'h1c;
    localparam logic [7:0] OFF_SET1     = 8'h20;
    localparam logic [7:0] OFF_CLR0     = 8'h28;
    localparam logic [7:0] OFF_CLR1     = 8'h2c;
    localparam logic [7:0] OFF_LVL0     = 8'h34;
    localparam logic [7:0] OFF_LVL1     = 8'h38;

    localparam logic [7:0] STORE_OFFSETS [STORE_WORDS] = '{
        8'h40, 8'h44, 8'h4c, 8'h50, 8'h58, 8'h5c, 8'h64, 8'h68, 8'h70,
        8'h74, 8'h7c, 8'h80, 8'h88, 8'h8c, 8'h94, 8'h98, 8'h9c
    };

    localparam int IN_DATA_W  = 104;
    localparam int IN_USED_W  = 101;
    localparam int OUT_DATA_W = 88;
    localparam int HI_W       = 22;

endpackage

// ----- rtl/core/gpio_register_block_top.sv -----
// Channel  | Dir | tdata (lowest bit up)                                  | tuser
// s_axis   | in  | offset 8, write_data 32, pin 6, pin_level 1,           | operation 2
//          |     | host_levels_low 32, host_levels_high 22, pad 3         |
// m_axis   | out | read_data 32, out_state_low 32, out_state_high 22, pad 2 | bad_offset 1
//
// One beat per cycle while m_axis is not stalled; each beat is registered at input and at output.
// Each beat is decoded and applied in combinational logic between the input register and
// the result register; all per-pin updates are parallel bitwise logic.
// Synchronous active-low reset clears the pin state and the valid flags.
// A stalled m_axis holds its beat; s_axis keeps taking beats while the input
// register can move forward.
module gpio_register_block_top
    import gpiorb_pkg::*;
#(
    parameter int PIN_COUNT = 54
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // offset, write_data, pin, pin_level, host_lo, host_hi
    input  logic [1:0]            i_s_axis_tuser,  // operation
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // read_data, out_state_low, out_state_high
    output logic                  o_m_axis_tuser   // bad_offset
);

    logic                 r_in_valid;
    logic [1:0]           r_in_op;
    logic [IN_USED_W-1:0] r_in_data;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_bad;

    logic [31:0] r_fsel [FSEL_WORDS];
    logic [31:0] r_dp   [STORE_WORDS];
    logic [MAX_PINS-1:0] r_set;
    logic [MAX_PINS-1:0] r_clr;
    logic [MAX_PINS-1:0] r_lvl;
    logic [MAX_PINS-1:0] r_pout;

    logic [31:0] n_fsel [FSEL_WORDS];
    logic [MAX_PINS-1:0] n_set_w;
    logic [MAX_PINS-1:0] n_clr_w;
    logic [MAX_PINS-1:0] n_set;
    logic [MAX_PINS-1:0] n_clr;
    logic [MAX_PINS-1:0] n_lvl;
    logic [MAX_PINS-1:0] n_pout;

    logic        advance;
    logic        fire;
    logic [7:0]  f_off;
    logic [31:0] f_wdata;
    logic [5:0]  f_pin;
    logic        f_lvl;
    logic [31:0] f_hlo;
    logic [HI_W-1:0] f_hhi;

    t_kind       kind;
    logic [4:0]  idx;
    logic        wr_ok;
    logic [2:0]  fn [MAX_PINS];
    logic [MAX_PINS-1:0] is_in;
    logic [MAX_PINS-1:0] is_out;
    logic [MAX_PINS-1:0] host;
    logic [MAX_PINS-1:0] lvl_copy;
    logic [MAX_PINS-1:0] act_set;
    logic [MAX_PINS-1:0] act_clr;
    logic [MAX_PINS-1:0] ev_mask;
    logic [31:0] rd;
    logic        bad;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    assign f_off   = r_in_data[7:0];
    assign f_wdata = r_in_data[39:8];
    assign f_pin   = r_in_data[45:40];
    assign f_lvl   = r_in_data[46];
    assign f_hlo   = r_in_data[78:47];
    assign f_hhi   = r_in_data[100:79];

    always_comb begin
        kind = K_NONE;
        idx  = 5'd0;
        if (f_off <= OFF_SEL_LAST && f_off[1:0] == 2'b00) begin
            kind = K_SELECT;
            idx  = {2'b00, f_off[4:2]};
        end else if (f_off == OFF_SET0 || f_off == OFF_SET1) begin
            kind = K_SET;
            idx  = {4'd0, f_off == OFF_SET1};
        end else if (f_off == OFF_CLR0 || f_off == OFF_CLR1) begin
            kind = K_CLEAR;
            idx  = {4'd0, f_off == OFF_CLR1};
        end else if (f_off == OFF_LVL0 || f_off == OFF_LVL1) begin
            kind = K_LEVEL;
            idx  = {4'd0, f_off == OFF_LVL1};
        end else begin
            for (int i = 0; i < STORE_WORDS; i++) begin
                if (STORE_OFFSETS[i] == f_off) begin
                    kind = K_STORE;
                    idx  = 5'(i);
                end
            end
        end
    end

    assign wr_ok = (r_in_op == OP_WRITE) && (kind != K_NONE) && (kind != K_LEVEL);

    always_comb begin
        n_fsel  = r_fsel;
        n_set_w = r_set;
        n_clr_w = r_clr;
        if (wr_ok) begin
            case (kind)
                K_SELECT: n_fsel[idx[2:0]] = f_wdata;
                K_SET: begin
                    if (idx[0]) n_set_w[63:32] = f_wdata;
                    else        n_set_w[31:0]  = f_wdata;
                end
                K_CLEAR: begin
                    if (idx[0]) n_clr_w[63:32] = f_wdata;
                    else        n_clr_w[31:0]  = f_wdata;
                end
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < MAX_PINS; g++) begin : g_pin
        if (g < FSEL_PINS) begin : g_sel
            assign fn[g] = n_fsel[g / 10][3 * (g % 10) +: 3];
        end else begin : g_nosel
            assign fn[g] = FN_INPUT;
        end
        assign is_in[g]  = (g < PIN_COUNT) && (fn[g] == FN_INPUT);
        assign is_out[g] = (g < PIN_COUNT) && (fn[g] == FN_OUTPUT);
    end

    assign host     = {10'd0, f_hhi, f_hlo};
    assign lvl_copy = (r_lvl & ~is_in) | (host & is_in);
    assign act_set  = n_set_w & is_out;
    assign act_clr  = n_clr_w & ~n_set_w & is_out;
    assign ev_mask  = is_in[f_pin] ? (64'd1 << f_pin) : 64'd0;

    always_comb begin
        n_set  = r_set;
        n_clr  = r_clr;
        n_pout = r_pout;
        n_lvl  = r_lvl;
        rd     = 32'd0;
        bad    = 1'b0;
        case (r_in_op)
            OP_READ: begin
                n_lvl = lvl_copy;
                case (kind)
                    K_SELECT: rd = r_fsel[idx[2:0]];
                    K_LEVEL:  rd = idx[0] ? lvl_copy[63:32] : lvl_copy[31:0];
                    K_STORE:  rd = r_dp[idx];
                    default:  bad = 1'b1;
                endcase
            end
            OP_WRITE: begin
                if (wr_ok) begin
                    n_set  = n_set_w & ~act_set;
                    n_clr  = n_clr_w & ~act_clr;
                    n_pout = (r_pout | act_set) & ~act_clr;
                end else begin
                    bad = 1'b1;
                end
            end
            OP_EVENT: n_lvl = (r_lvl & ~ev_mask) | (f_lvl ? ev_mask : 64'd0);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_set       <= '0;
            r_clr       <= '0;
            r_lvl       <= '0;
            r_pout      <= '0;
            for (int i = 0; i < FSEL_WORDS; i++) r_fsel[i] <= '0;
            for (int i = 0; i < STORE_WORDS; i++) r_dp[i] <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_fsel <= n_fsel;
                r_set  <= n_set;
                r_clr  <= n_clr;
                r_lvl  <= n_lvl;
                r_pout <= n_pout;
                if (wr_ok && kind == K_STORE) r_dp[idx] <= f_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_op   <= i_s_axis_tuser;
            r_in_data <= i_s_axis_tdata[IN_USED_W-1:0];
        end
        if (fire) begin
            r_out_data <= {2'b00, n_pout[53:32], n_pout[31:0], rd};
            r_out_bad  <= bad;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_bad;

endmodule

// ----- rtl/core/gpiorb_chk.sv -----
module gpiorb_chk
    import gpiorb_pkg::*;
#(
    parameter int PIN_COUNT = 54
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [1:0]            i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tuser
);

    localparam int HI_PINS = (PIN_COUNT - 32 > HI_W) ? HI_W : PIN_COUNT - 32;

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("m_axis valid after reset");

    a_bad_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[31:0] == 32'd0)
        else $error("bad offset beat with nonzero read data");

    a_no_phantom_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[85:64] >> HI_PINS) == '0)
        else $error("output state set on a pin beyond the pin count");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("m_axis beat dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("m_axis beat changed while stalled");

endmodule

bind gpio_register_block_top gpiorb_chk #(.PIN_COUNT(PIN_COUNT)) u_gpiorb_chk (.*);

// ----- tb/tb_gpio_register_block_top.sv -----
`timescale 1ns / 100ps

module tb_gpio_register_block_top;
    import gpiorb_pkg::*;

    localparam int PINS = 54;
    localparam logic [1:0] OP_IDLE = 2'd3;
    localparam logic [31:0] ALL_OUTPUT = 32'h0924_9249;
    localparam int RANDOM_REQS = 1050;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  offset;
        logic [31:0] wdata;
        logic [5:0]  pin;
        logic        lvl;
        logic [31:0] host_lo;
        logic [21:0] host_hi;
        bit          drain;
    } t_gpio_req;

    typedef struct {
        logic [31:0] read_data;
        logic        bad_offset;
        logic [31:0] out_lo;
        logic [21:0] out_hi;
    } t_gpio_resp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;  // offset, write_data, pin, pin_level, host_lo, host_hi
    logic [1:0]            i_s_axis_tuser = '0;  // operation
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;       // read_data, out_state_low, out_state_high
    logic                  o_m_axis_tuser;       // bad_offset

    gpio_register_block_top #(
        .PIN_COUNT(PINS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_gpio_req  bus_requests[$];
    t_gpio_resp expected_responses[$];

    logic [31:0] fsel_words [FSEL_WORDS];
    logic [31:0] store_words [STORE_WORDS];
    logic [63:0] set_pending;
    logic [63:0] clear_pending;
    logic [63:0] pin_levels;
    logic [63:0] out_state;

    int n_reads, n_writes, n_events, n_idle, n_flagged, n_checked, n_errors;

    function automatic logic [2:0] pin_fn(int p);
        if (p >= FSEL_PINS) return FN_INPUT;
        return 3'(fsel_words[p / 10] >> (3 * (p % 10)));
    endfunction

    function automatic logic [63:0] pins_with_fn(logic [2:0] fn);
        logic [63:0] m;
        m = '0;
        for (int p = 0; p < PINS; p++) begin
            if (pin_fn(p) == fn) m[p] = 1'b1;
        end
        return m;
    endfunction

    function automatic t_kind decode_offset(logic [7:0] off, output int idx);
        idx = 0;
        if (off <= OFF_SEL_LAST && off[1:0] == 2'b00) begin
            idx = off >> 2;
            return K_SELECT;
        end
        if (off == OFF_SET0 || off == OFF_SET1) begin
            idx = (off == OFF_SET1);
            return K_SET;
        end
        if (off == OFF_CLR0 || off == OFF_CLR1) begin
            idx = (off == OFF_CLR1);
            return K_CLEAR;
        end
        if (off == OFF_LVL0 || off == OFF_LVL1) begin
            idx = (off == OFF_LVL1);
            return K_LEVEL;
        end
        for (int i = 0; i < STORE_WORDS; i++) begin
            if (STORE_OFFSETS[i] == off) begin
                idx = i;
                return K_STORE;
            end
        end
        return K_NONE;
    endfunction

    task automatic gpio_predict(input t_gpio_req r);
        t_gpio_resp e;
        t_kind      kind;
        int         idx;
        logic [63:0] ins, outs, set_hit, clr_hit;
        e = '{default: '0};
        case (r.op)
            OP_READ: begin
                n_reads++;
                ins = pins_with_fn(FN_INPUT);
                pin_levels = (pin_levels & ~ins) | ({10'b0, r.host_hi, r.host_lo} & ins);
                kind = decode_offset(r.offset, idx);
                case (kind)
                    K_SELECT: e.read_data = fsel_words[idx];
                    K_LEVEL:  e.read_data = pin_levels[32*idx +: 32];
                    K_STORE:  e.read_data = store_words[idx];
                    default:  e.bad_offset = 1'b1;
                endcase
            end
            OP_WRITE: begin
                n_writes++;
                kind = decode_offset(r.offset, idx);
                if (kind == K_NONE || kind == K_LEVEL) begin
                    e.bad_offset = 1'b1;
                end else begin
                    case (kind)
                        K_SELECT: fsel_words[idx] = r.wdata;
                        K_SET:    set_pending[32*idx +: 32] = r.wdata;
                        K_CLEAR:  clear_pending[32*idx +: 32] = r.wdata;
                        default:  store_words[idx] = r.wdata;
                    endcase
                    outs = pins_with_fn(FN_OUTPUT);
                    set_hit = set_pending & outs;
                    clr_hit = clear_pending & outs & ~set_pending;
                    out_state = (out_state | set_hit) & ~clr_hit;
                    set_pending &= ~set_hit;
                    clear_pending &= ~clr_hit;
                end
            end
            OP_EVENT: begin
                n_events++;
                if (r.pin < PINS && pin_fn(r.pin) == FN_INPUT) pin_levels[r.pin] = r.lvl;
            end
            default: n_idle++;
        endcase
        if (e.bad_offset) n_flagged++;
        e.out_lo = out_state[31:0];
        e.out_hi = out_state[53:32];
        expected_responses.push_back(e);
    endtask

    task automatic push_req(input logic [1:0] op, input logic [7:0] off, input logic [31:0] data,
                            input logic [5:0] pin, input logic lvl, input logic [31:0] lo,
                            input logic [21:0] hi, input bit drain);
        t_gpio_req r;
        r.op = op;
        r.offset = off;
        r.wdata = data;
        r.pin = pin;
        r.lvl = lvl;
        r.host_lo = lo;
        r.host_hi = hi;
        r.drain = drain;
        bus_requests.push_back(r);
    endtask

    function automatic logic [7:0] rand_offset();
        case ($urandom_range(0, 7))
            0: return 8'($urandom_range(0, 255));
            1, 2: return 8'($urandom_range(0, 5) * 4);
            3: return $urandom_range(0, 1) ? OFF_SET0 : OFF_SET1;
            4: return $urandom_range(0, 1) ? OFF_CLR0 : OFF_CLR1;
            5: return $urandom_range(0, 1) ? OFF_LVL0 : OFF_LVL1;
            default: return STORE_OFFSETS[$urandom_range(0, STORE_WORDS - 1)];
        endcase
    endfunction

    function automatic logic [31:0] rand_fsel_word();
        logic [31:0] w;
        w = $urandom();
        for (int j = 0; j < 10; j++) begin
            w[3*j +: 3] = ($urandom_range(0, 3) == 0) ? 3'($urandom()) : 3'($urandom_range(0, 1));
        end
        return w;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    t_gpio_req cur_req;
    logic      presenting = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                gpio_predict(cur_req);
                presenting = 1'b0;
            end
            if (!presenting) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (bus_requests.size() > 0 &&
                             !(bus_requests[0].drain && expected_responses.size() > 0)) begin
                    cur_req = bus_requests.pop_front();
                    presenting = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
            i_s_axis_tvalid <= presenting;
            i_s_axis_tuser <= cur_req.op;
            i_s_axis_tdata <= {3'b0, cur_req.host_hi, cur_req.host_lo, cur_req.lvl, cur_req.pin,
                               cur_req.wdata, cur_req.offset};
        end
    end

    logic [15:0] stall_pattern = '1;
    int          stall_age = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (stall_age == 0) begin
                stall_age = $urandom_range(20, 90);
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom()) | 16'h1;
            end else begin
                stall_age--;
            end
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            i_m_axis_tready <= stall_pattern[0];
        end
    end

    always @(posedge i_clk) begin
        t_gpio_resp e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_responses.size() == 0) begin
                $error("unexpected result beat: tdata %h tuser %b", o_m_axis_tdata, o_m_axis_tuser);
                n_errors++;
            end else begin
                e = expected_responses.pop_front();
                n_checked++;
                if (o_m_axis_tdata[31:0] !== e.read_data) begin
                    $error("read_data: expected %h, got %h", e.read_data, o_m_axis_tdata[31:0]);
                    n_errors++;
                end
                if (o_m_axis_tuser !== e.bad_offset) begin
                    $error("bad_offset: expected %b, got %b", e.bad_offset, o_m_axis_tuser);
                    n_errors++;
                end
                if (o_m_axis_tdata[63:32] !== e.out_lo) begin
                    $error("out_state_low: expected %h, got %h", e.out_lo, o_m_axis_tdata[63:32]);
                    n_errors++;
                end
                if (o_m_axis_tdata[85:64] !== e.out_hi) begin
                    $error("out_state_high: expected %h, got %h", e.out_hi, o_m_axis_tdata[85:64]);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        logic [1:0]  op;
        logic [7:0]  off;
        int          k;
        for (int i = 0; i < FSEL_WORDS; i++) fsel_words[i] = '0;
        for (int i = 0; i < STORE_WORDS; i++) store_words[i] = '0;
        set_pending = '0;
        clear_pending = '0;
        pin_levels = '0;
        out_state = '0;

        push_req(OP_READ, OFF_LVL0, '1, 6'd0, 1'b0, '1, '1, 1'b0);
        push_req(OP_READ, OFF_LVL1, '0, 6'd63, 1'b1, '1, '1, 1'b0);
        push_req(OP_WRITE, 8'h00, ALL_OUTPUT, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_WRITE, OFF_SET0, '1, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_WRITE, OFF_CLR0, 32'h0000_03f0, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_WRITE, OFF_CLR1, '1, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_WRITE, OFF_SET1, '1, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_WRITE, OFF_SEL_LAST, ALL_OUTPUT, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_WRITE, 8'h10, ALL_OUTPUT, 6'd0, 1'b0, '0, '0, 1'b1);
        push_req(OP_WRITE, 8'h08, 32'hffff_ffff, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_READ, 8'h08, '0, 6'd0, 1'b0, 32'h5555_5555, 22'h2a_aaaa, 1'b0);
        push_req(OP_WRITE, OFF_LVL0, '1, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_WRITE, 8'h18, '1, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_WRITE, 8'h01, '1, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_READ, OFF_SET0, '0, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_READ, OFF_CLR1, '0, 6'd0, 1'b0, '1, '1, 1'b0);
        push_req(OP_READ, 8'hff, '0, 6'd0, 1'b0, '1, '1, 1'b0);
        push_req(OP_WRITE, 8'h40, 32'ha5a5_a5a5, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_WRITE, 8'h9c, '1, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_READ, 8'h9c, '0, 6'd0, 1'b0, '0, '0, 1'b0);
        push_req(OP_EVENT, 8'h00, '1, 6'd31, 1'b1, '0, '0, 1'b0);
        push_req(OP_EVENT, 8'h00, '0, 6'd5, 1'b1, '0, '0, 1'b0);
        push_req(OP_EVENT, 8'h00, '0, 6'd63, 1'b1, '0, '0, 1'b0);
        push_req(OP_IDLE, 8'h34, '1, 6'd31, 1'b0, '1, '1, 1'b0);
        push_req(OP_WRITE, 8'h0c, '0, 6'd0, 1'b0, '0, '0, 1'b0);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            k = $urandom_range(0, 99);
            op = (k < 35) ? OP_READ : (k < 80) ? OP_WRITE : (k < 95) ? OP_EVENT : OP_IDLE;
            off = rand_offset();
            push_req(op, off, (off <= OFF_SEL_LAST) ? rand_fsel_word() : rand_word(),
                     6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), $urandom(),
                     22'($urandom()), (i % 250) == 249);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bus_requests.size() != 0 || presenting || expected_responses.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d reads, %0d writes, %0d pin events, %0d idle operations",
                 n_reads, n_writes, n_events, n_idle);
        $display("checked %0d result beats, %0d with a flagged offset", n_checked, n_flagged);
        if (n_errors == 0 && expected_responses.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end

endmodule
